// ===== design/gomms_pkg.sv =====
// gomms_pkg: shared constants, types and controller states of the greedy match selector
// no dependencies; imported by the interfaces, controller, datapath and top level
package gomms_pkg;

   localparam int MAX_CANDIDATES = 64;
   localparam int IDX_W          = $clog2(MAX_CANDIDATES);
   localparam int CNT_W          = $clog2(MAX_CANDIDATES + 1);
   localparam int GRID_W         = 16;
   localparam int DIST_W         = 32;

   typedef struct packed {
      logic [GRID_W-1:0] first;
      logic [GRID_W-1:0] second;
      logic [DIST_W-1:0] dist_key;
   } cand_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEAD_GO,
      ST_LEAD_WAIT,
      ST_PICK_GO,
      ST_PICK_WAIT,
      ST_EMIT,
      ST_FLUSH,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic accept_ok;
      logic scan_start;
      logic scan_pick;
      logic advance;
      logic flush;
      logic clear;
   } ctrl_cmd_type;

   typedef struct packed {
      logic run_start;
      logic scan_busy;
      logic lead_found;
      logic pick_found;
      logic pend_valid;
      logic out_free;
   } dp_status_type;

endpackage

// ===== design/gomms_if.sv =====
// gomms_req_if / gomms_rsp_if: valid/ready channels for candidate and result transactions
// depends on gomms_pkg for field widths
interface gomms_req_if
   import gomms_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [GRID_W-1:0] first_grid;
   logic [GRID_W-1:0] second_grid;
   logic [DIST_W-1:0] match_distance;
   logic              end_of_list;

   modport source (output valid, first_grid, second_grid, match_distance, end_of_list,
                   input ready);
   modport sink   (input valid, first_grid, second_grid, match_distance, end_of_list,
                   output ready);
endinterface

interface gomms_rsp_if
   import gomms_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [GRID_W-1:0] chosen_first;
   logic [GRID_W-1:0] chosen_second;
   logic [DIST_W-1:0] chosen_distance;
   logic              last_result;

   modport source (output valid, chosen_first, chosen_second, chosen_distance, last_result,
                   input ready);
   modport sink   (input valid, chosen_first, chosen_second, chosen_distance, last_result,
                   output ready);
endinterface

// ===== design/gomms_ctrl.sv =====
// gomms_ctrl: sequencer for load, group-lead scan, pick scan, emit, flush and end-of-run clear
// depends on gomms_pkg; drives the datapath through ctrl_cmd_type only
module gomms_ctrl
   import gomms_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output state_type     state
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (status.run_start) state_in = ST_LEAD_GO;
         end
         ST_LEAD_GO: begin
            state_in = ST_LEAD_WAIT;
         end
         ST_LEAD_WAIT: begin
            if (!status.scan_busy) state_in = status.lead_found ? ST_PICK_GO : ST_FLUSH;
         end
         ST_PICK_GO: begin
            state_in = ST_PICK_WAIT;
         end
         ST_PICK_WAIT: begin
            if (!status.scan_busy) state_in = status.pick_found ? ST_EMIT : ST_LEAD_GO;
         end
         ST_EMIT: begin
            if (!status.pend_valid || status.out_free) state_in = ST_LEAD_GO;
         end
         ST_FLUSH: begin
            if (!status.pend_valid || status.out_free) state_in = ST_CLEAR;
         end
         ST_CLEAR: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept_ok = 1'b1;
         end
         ST_LEAD_GO: begin
            cmd.scan_start = 1'b1;
         end
         ST_LEAD_WAIT: begin
            cmd.scan_pick = 1'b0;
         end
         ST_PICK_GO: begin
            cmd.scan_start = 1'b1;
            cmd.scan_pick  = 1'b1;
         end
         ST_PICK_WAIT: begin
            cmd.scan_pick = 1'b1;
         end
         ST_EMIT: begin
            cmd.advance = !status.pend_valid || status.out_free;
         end
         ST_FLUSH: begin
            cmd.flush = status.pend_valid && status.out_free;
         end
         ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign state = state_ff;

endmodule

// ===== design/gomms_dp.sv =====
// gomms_dp: candidate store, scan engine, taken/visited flags, pending and output registers
// depends on gomms_pkg and the gomms_req_if / gomms_rsp_if channels
module gomms_dp
   import gomms_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   gomms_req_if.sink     req_chan,
   gomms_rsp_if.source   rsp_chan,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status
);

   cand_type                cand_store_ff [MAX_CANDIDATES];
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;

   logic [CNT_W-1:0]        addr_ff;
   logic                    running_ff;
   logic                    rd_vld_ff;
   cand_type                rd_data_ff;
   logic [IDX_W-1:0]        rd_idx_ff;

   logic [MAX_CANDIDATES-1:0] taken_ff, taken_in;
   logic [MAX_CANDIDATES-1:0] done_ff, done_in;

   logic                    lead_vld_ff, lead_vld_in;
   logic [GRID_W-1:0]       lead_first_ff, lead_first_in;
   logic [DIST_W-1:0]       lead_dist_ff, lead_dist_in;

   logic                    pick_vld_ff, pick_vld_in;
   cand_type                pick_ff, pick_in;

   logic                    pend_vld_ff, pend_vld_in;
   cand_type                pend_ff, pend_in;

   logic                    take_vld_ff, take_vld_in;
   logic [GRID_W-1:0]       take_second_ff, take_second_in;

   logic                    out_vld_ff, out_vld_in;
   cand_type                out_ff, out_in;
   logic                    out_last_ff, out_last_in;

   logic                    accept;
   logic                    room;
   logic                    issue;
   logic                    out_free;
   logic                    lead_better;
   cand_type                wr_data;

   assign req_chan.ready = cmd.accept_ok;
   assign accept         = req_chan.valid && cmd.accept_ok;
   assign room           = count_ff < CNT_W'(MAX_CANDIDATES);
   assign wr_data        = '{first:    req_chan.first_grid,
                             second:   req_chan.second_grid,
                             dist_key: req_chan.match_distance};

   // candidate store
   always_ff @(posedge clock) begin
      if (accept && room) begin
         cand_store_ff[count_ff[IDX_W-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= cand_store_ff[addr_ff[IDX_W-1:0]];
      rd_idx_ff  <= addr_ff[IDX_W-1:0];
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (accept && room) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // scan address sequencer
   assign issue = running_ff && (addr_ff < count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         rd_vld_ff  <= 1'b0;
         addr_ff    <= '0;
      end else begin
         rd_vld_ff <= issue;
         if (cmd.scan_start) begin
            running_ff <= 1'b1;
            addr_ff    <= '0;
         end else if (issue) begin
            addr_ff <= addr_ff + CNT_W'(1);
         end else begin
            running_ff <= 1'b0;
         end
      end
   end

   assign out_free = !out_vld_ff || rsp_chan.ready;
   assign lead_better = !lead_vld_ff || (rd_data_ff.dist_key < lead_dist_ff) ||
                        ((rd_data_ff.dist_key == lead_dist_ff) &&
                         (rd_data_ff.first < lead_first_ff));

   always_comb begin
      taken_in       = taken_ff;
      done_in        = done_ff;
      lead_vld_in    = lead_vld_ff;
      lead_first_in  = lead_first_ff;
      lead_dist_in   = lead_dist_ff;
      pick_vld_in    = pick_vld_ff;
      pick_in        = pick_ff;
      pend_vld_in    = pend_vld_ff;
      pend_in        = pend_ff;
      take_vld_in    = take_vld_ff;
      take_second_in = take_second_ff;
      out_vld_in     = out_vld_ff && !rsp_chan.ready;
      out_in         = out_ff;
      out_last_in    = out_last_ff;

      // lead scan: mark entries sharing the last picked second id, track group lead
      if (rd_vld_ff && !cmd.scan_pick) begin
         if (take_vld_ff && (rd_data_ff.second == take_second_ff)) begin
            taken_in[rd_idx_ff] = 1'b1;
         end
         if (!done_ff[rd_idx_ff] && lead_better) begin
            lead_vld_in   = 1'b1;
            lead_first_in = rd_data_ff.first;
            lead_dist_in  = rd_data_ff.dist_key;
         end
      end

      // pick scan: visit the group, keep the earliest lowest-distance free entry
      if (rd_vld_ff && cmd.scan_pick && (rd_data_ff.first == lead_first_ff)) begin
         done_in[rd_idx_ff] = 1'b1;
         if (!taken_ff[rd_idx_ff] &&
             (!pick_vld_ff || (rd_data_ff.dist_key < pick_ff.dist_key))) begin
            pick_vld_in = 1'b1;
            pick_in     = rd_data_ff;
         end
      end

      if (cmd.scan_start) begin
         if (cmd.scan_pick) begin
            pick_vld_in = 1'b0;
         end else begin
            lead_vld_in = 1'b0;
         end
      end

      // previous pending result goes out, new pick becomes pending
      if (cmd.advance) begin
         if (pend_vld_ff) begin
            out_vld_in  = 1'b1;
            out_in      = pend_ff;
            out_last_in = 1'b0;
         end
         pend_vld_in    = 1'b1;
         pend_in        = pick_ff;
         take_vld_in    = 1'b1;
         take_second_in = pick_ff.second;
      end

      if (cmd.flush) begin
         out_vld_in  = 1'b1;
         out_in      = pend_ff;
         out_last_in = 1'b1;
         pend_vld_in = 1'b0;
      end

      if (cmd.clear) begin
         taken_in    = '0;
         done_in     = '0;
         take_vld_in = 1'b0;
         pend_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         taken_ff    <= '0;
         done_ff     <= '0;
         lead_vld_ff <= 1'b0;
         pick_vld_ff <= 1'b0;
         pend_vld_ff <= 1'b0;
         take_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         count_ff    <= count_in;
         taken_ff    <= taken_in;
         done_ff     <= done_in;
         lead_vld_ff <= lead_vld_in;
         pick_vld_ff <= pick_vld_in;
         pend_vld_ff <= pend_vld_in;
         take_vld_ff <= take_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      lead_first_ff  <= lead_first_in;
      lead_dist_ff   <= lead_dist_in;
      pick_ff        <= pick_in;
      pend_ff        <= pend_in;
      take_second_ff <= take_second_in;
      out_ff         <= out_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_chan.valid           = out_vld_ff;
   assign rsp_chan.chosen_first    = out_ff.first;
   assign rsp_chan.chosen_second   = out_ff.second;
   assign rsp_chan.chosen_distance = out_ff.dist_key;
   assign rsp_chan.last_result     = out_last_ff;

   assign status.run_start  = accept && req_chan.end_of_list;
   assign status.scan_busy  = running_ff || rd_vld_ff;
   assign status.lead_found = lead_vld_ff;
   assign status.pick_found = pick_vld_ff;
   assign status.pend_valid = pend_vld_ff;
   assign status.out_free   = out_free;

endmodule

// ===== design/greedy_one_to_one_match_selector.sv =====
// greedy_one_to_one_match_selector: top level, controller plus datapath
// depends on gomms_pkg, gomms_if, gomms_ctrl and gomms_dp
//
// channel    dir  payload                                              handshake
// req_chan   in   first_grid, second_grid, match_distance, end_of_list valid/ready
// rsp_chan   out  chosen_first, chosen_second, chosen_distance, last_result valid/ready
//
// loading takes one transaction per cycle while idle; end_of_list starts a run
// a run alternates group-lead scans and pick scans over all n stored candidates
// (one store read port) with an emit step per result, then a flush and a clear step
// req_chan.ready stays low for the whole run; rsp_chan stalls hold the emit and flush steps
// synchronous reset clears counts and flags at once; no clearing pass is needed
module greedy_one_to_one_match_selector
   import gomms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   gomms_req_if.sink   req_chan,
   gomms_rsp_if.source rsp_chan
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   state_type     state;

   gomms_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd),
      .state  (state)
   );

   gomms_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cmd      (cmd),
      .status   (status)
   );

`ifndef SYNTHESIS
   // no new candidates while a result is still pending
   a_ready_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !status.pend_valid)
      else $error("ready while a result is pending");

   // a last transaction locks the input for the run
   a_run_locks_input: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.end_of_list) |=> !req_chan.ready)
      else $error("input not stalled after end of list");

   // a scan never restarts over one still running
   a_scan_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_start |-> !status.scan_busy)
      else $error("scan started while busy");

   // a pick scan only runs for a found group lead
   a_pick_has_lead: assert property (@(posedge clock) disable iff (reset)
      (state == ST_PICK_GO) |-> status.lead_found)
      else $error("pick scan without group lead");
`endif

endmodule
